/* hw/rtl/prq_pkg.sv */
`default_nettype none

package prq_pkg;

   localparam int NUM_TASKS  = 32;
   localparam int NUM_LEVELS = 32;
   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int LEVEL_W    = $clog2(NUM_LEVELS);

   typedef enum logic [1:0] {
      FUNC_READY   = 2'd0,
      FUNC_UNREADY = 2'd1,
      FUNC_REPRIO  = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UNLINK_RD,
      ST_UNLINK_WR,
      ST_APPEND_RD,
      ST_APPEND_WR,
      ST_APPEND_NX,
      ST_SEL_ENC,
      ST_SEL_RD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [TASK_W-1:0]  task_id;
      logic [LEVEL_W-1:0] prio;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0] next_task;
      logic              next_valid;
      logic              op_error;
   } rsp_type;

   typedef struct packed {
      logic               any;
      logic [LEVEL_W-1:0] lvl;
   } sel_type;

endpackage

`default_nettype wire

/* hw/rtl/prq_lsb_enc.sv */
`default_nettype none

module prq_lsb_enc
   import prq_pkg::*;
(
   input  wire logic [NUM_LEVELS-1:0] bitmap,
   output sel_type                    sel
);

   logic [NUM_LEVELS-1:0] onehot;
   logic [LEVEL_W-1:0]    lvl;

   // isolate lowest set bit, then or-encode the one-hot word
   assign onehot = bitmap & (~bitmap + NUM_LEVELS'(1));

   always_comb begin
      lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (onehot[i]) begin
            lvl = lvl | LEVEL_W'(i);
         end
      end
   end

   assign sel.any = |bitmap;
   assign sel.lvl = lvl;

endmodule

`default_nettype wire

/* hw/rtl/priority_ready_queue_scheduler.sv */
`default_nettype none

// Ready-queue scheduler: one FIFO of task ids per priority level, held as
// doubly linked lists, with a ready bitmap over the levels (level 0 highest).
// Request beat on req_*: func (make runnable, make non-runnable, change
// priority), task_id and prio. Each request gives exactly one
// response beat on rsp_*: next_task, next_valid and op_error. A refused
// request leaves all state unchanged and still reports the current choice.
// A request is taken when req_valid is high and req_stall low; req_stall is
// high while a request is being worked. Each request walks a small
// sequencer that does one read or one write of each link store per cycle;
// a change of priority, or making the last task of a level non-runnable,
// also runs the lowest-set-bit search over the bitmap.
// The response is valid from the cycle after the last step.
// The response sits in an output register; while rsp_stall is high it holds
// and the sequencer waits in its last step, and no further request is taken.
// Synchronous reset empties every queue, clears all runnable marks and the
// choice, and drops rsp_valid. The link and priority stores need no reset.
module priority_ready_queue_scheduler
   import prq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic [TASK_W-1:0]  link_next_ff  [NUM_TASKS];
   logic [TASK_W-1:0]  link_prev_ff  [NUM_TASKS];
   logic [TASK_W-1:0]  level_head_ff [NUM_LEVELS];
   logic [TASK_W-1:0]  level_tail_ff [NUM_LEVELS];
   logic [LEVEL_W-1:0] task_prio_ff  [NUM_TASKS];

   state_type             state_ff, state_in;
   logic [1:0]            func_ff, func_in;
   logic [TASK_W-1:0]     tid_ff, tid_in;
   logic [LEVEL_W-1:0]    prio_ff, prio_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic                  err_ff, err_in;
   logic [TASK_W-1:0]     head_ff, head_in;
   logic [TASK_W-1:0]     tail_ff, tail_in;
   logic [TASK_W-1:0]     prev_ff, prev_in;
   logic [TASK_W-1:0]     next_ff, next_in;
   logic [LEVEL_W-1:0]    cprio_ff, cprio_in;
   sel_type               sel_ff, sel_in;
   logic [NUM_LEVELS-1:0] bitmap_ff, bitmap_in;
   logic [NUM_TASKS-1:0]  runnable_ff, runnable_in;
   logic [TASK_W-1:0]     chosen_ff, chosen_in;
   logic                  chosen_valid_ff, chosen_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // store ports
   logic               nx_we, pv_we, hd_we, tl_we, pr_we;
   logic [TASK_W-1:0]  nx_wa, nx_wd, pv_wa, pv_wd, hd_wd, tl_wd;
   logic [LEVEL_W-1:0] hd_wa, tl_wa, pr_wd;
   logic [LEVEL_W-1:0] hd_ra, tl_ra;
   logic [TASK_W-1:0]  pr_ra;
   logic [TASK_W-1:0]  hd_rd, tl_rd;
   logic [LEVEL_W-1:0] pr_rd;

   logic    err, is_head, is_tail;
   sel_type enc_sel;

   prq_lsb_enc u_enc (
      .bitmap (bitmap_ff),
      .sel    (enc_sel)
   );

   assign hd_ra = (state_ff == ST_SEL_RD) ? sel_ff.lvl : lvl_ff;
   assign tl_ra = (state_ff == ST_APPEND_RD) ? prio_ff : lvl_ff;
   assign pr_ra = (state_ff == ST_APPEND_RD) ? chosen_ff : tid_ff;
   assign hd_rd = level_head_ff[hd_ra];
   assign tl_rd = level_tail_ff[tl_ra];
   assign pr_rd = task_prio_ff[pr_ra];

   assign is_head = (head_ff == tid_ff);
   assign is_tail = (tail_ff == tid_ff);

   always_comb begin
      state_in        = state_ff;
      func_in         = func_ff;
      tid_in          = tid_ff;
      prio_in         = prio_ff;
      lvl_in          = lvl_ff;
      err_in          = err_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      prev_in         = prev_ff;
      next_in         = next_ff;
      cprio_in        = cprio_ff;
      sel_in          = sel_ff;
      bitmap_in       = bitmap_ff;
      runnable_in     = runnable_ff;
      chosen_in       = chosen_ff;
      chosen_valid_in = chosen_valid_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      nx_we = 1'b0; nx_wa = tid_ff; nx_wd = tid_ff;
      pv_we = 1'b0; pv_wa = tid_ff; pv_wd = tid_ff;
      hd_we = 1'b0; hd_wa = prio_ff; hd_wd = tid_ff;
      tl_we = 1'b0; tl_wa = prio_ff; tl_wd = tid_ff;
      pr_we = 1'b0; pr_wd = prio_ff;
      err   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_payload.func;
               tid_in   = req_payload.task_id;
               prio_in  = req_payload.prio;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority case (func_ff)
               FUNC_READY:   err = runnable_ff[tid_ff];
               FUNC_UNREADY: err = !runnable_ff[tid_ff];
               FUNC_REPRIO:  err = !runnable_ff[tid_ff];
               default:      err = 1'b1;
            endcase
            err_in = err;
            lvl_in = pr_rd;
            if (err) begin
               state_in = ST_FINISH;
            end else if (func_ff == FUNC_READY) begin
               pr_we               = 1'b1;
               runnable_in[tid_ff] = 1'b1;
               state_in            = ST_APPEND_RD;
            end else if (func_ff == FUNC_UNREADY) begin
               runnable_in[tid_ff] = 1'b0;
               state_in            = ST_UNLINK_RD;
            end else begin
               pr_we    = 1'b1;
               state_in = ST_UNLINK_RD;
            end
         end
         ST_UNLINK_RD: begin
            head_in  = hd_rd;
            tail_in  = tl_rd;
            prev_in  = link_prev_ff[tid_ff];
            next_in  = link_next_ff[tid_ff];
            state_in = ST_UNLINK_WR;
         end
         ST_UNLINK_WR: begin
            if (is_head && is_tail) begin
               bitmap_in[lvl_ff] = 1'b0;
               state_in = (func_ff == FUNC_UNREADY) ? ST_SEL_ENC : ST_APPEND_RD;
            end else begin
               if (is_head) begin
                  hd_we = 1'b1; hd_wa = lvl_ff; hd_wd = next_ff;
               end else begin
                  nx_we = 1'b1; nx_wa = prev_ff; nx_wd = next_ff;
               end
               if (is_tail) begin
                  tl_we = 1'b1; tl_wa = lvl_ff; tl_wd = prev_ff;
               end else begin
                  pv_we = 1'b1; pv_wa = next_ff; pv_wd = prev_ff;
               end
               if (func_ff == FUNC_UNREADY) begin
                  if (chosen_valid_ff && chosen_ff == tid_ff) begin
                     chosen_in = is_head ? next_ff : head_ff;
                  end
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_APPEND_RD;
               end
            end
         end
         ST_APPEND_RD: begin
            tail_in  = tl_rd;
            cprio_in = pr_rd;
            state_in = ST_APPEND_WR;
         end
         ST_APPEND_WR: begin
            if (!bitmap_ff[prio_ff]) begin
               hd_we = 1'b1;
               pv_we = 1'b1;
            end else begin
               nx_we = 1'b1; nx_wa = tail_ff;
               pv_we = 1'b1; pv_wd = tail_ff;
            end
            tl_we              = 1'b1;
            bitmap_in[prio_ff] = 1'b1;
            if (func_ff == FUNC_READY) begin
               if (!chosen_valid_ff) begin
                  chosen_in       = tid_ff;
                  chosen_valid_in = 1'b1;
               end else if (prio_ff < cprio_ff) begin
                  chosen_in = tid_ff;
               end
            end
            state_in = ST_APPEND_NX;
         end
         ST_APPEND_NX: begin
            nx_we    = 1'b1;
            state_in = (func_ff == FUNC_READY) ? ST_FINISH : ST_SEL_ENC;
         end
         ST_SEL_ENC: begin
            sel_in   = enc_sel;
            state_in = ST_SEL_RD;
         end
         ST_SEL_RD: begin
            chosen_valid_in = sel_ff.any;
            chosen_in       = sel_ff.any ? hd_rd : '0;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.next_task  = chosen_valid_ff ? chosen_ff : '0;
               rsp_in.next_valid = chosen_valid_ff;
               rsp_in.op_error   = err_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bitmap_ff       <= '0;
         runnable_ff     <= '0;
         chosen_ff       <= '0;
         chosen_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bitmap_ff       <= bitmap_in;
         runnable_ff     <= runnable_in;
         chosen_ff       <= chosen_in;
         chosen_valid_ff <= chosen_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      tid_ff   <= tid_in;
      prio_ff  <= prio_in;
      lvl_ff   <= lvl_in;
      err_ff   <= err_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      prev_ff  <= prev_in;
      next_ff  <= next_in;
      cprio_ff <= cprio_in;
      sel_ff   <= sel_in;
      rsp_ff   <= rsp_in;
   end

   // link and priority stores
   always_ff @(posedge clock) begin
      if (nx_we) begin
         link_next_ff[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         link_prev_ff[pv_wa] <= pv_wd;
      end
      if (hd_we) begin
         level_head_ff[hd_wa] <= hd_wd;
      end
      if (tl_we) begin
         level_tail_ff[tl_wa] <= tl_wd;
      end
      if (pr_we) begin
         task_prio_ff[tid_ff] <= pr_wd;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_choice_matches_bitmap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> chosen_valid_ff == (bitmap_ff != '0))
      else $error("choice validity disagrees with ready bitmap");

   a_choice_is_runnable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chosen_valid_ff || runnable_ff[chosen_ff])
      else $error("chosen task is not runnable");

   a_levels_need_tasks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(bitmap_ff) <= $countones(runnable_ff))
      else $error("more ready levels than runnable tasks");
`endif

endmodule

`default_nettype wire
